[sv/chunk_handle_map_table_unit_assert.svh]
// Assertion macros for the chunk handle map table.
`ifndef CHUNK_HANDLE_MAP_TABLE_UNIT_ASSERT_SVH
`define CHUNK_HANDLE_MAP_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define CHMT_ASSERT_HOLDS(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chmt: check failed");

// next-cycle implication
`define CHMT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chmt: check failed");

`endif

[sv/chmt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package chmt_pkg;

   localparam int CHMT_TABLE_DEPTH   = 64;
   localparam int CHMT_HISTORY_DEPTH = 32;

   localparam logic [2:0] OP_CREATE      = 3'd0;
   localparam logic [2:0] OP_DESTROY     = 3'd1;
   localparam logic [2:0] OP_LOOKUP      = 3'd2;
   localparam logic [2:0] OP_START_FRAME = 3'd3;
   localparam logic [2:0] OP_CLEAR_ALL   = 3'd4;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [63:0] chunk_id;
      logic [31:0] handle_slot;
      logic [31:0] handle_generation;
      logic        fallback_flag;
   } req_type;

   typedef struct packed {
      logic        success;
      logic [31:0] found_slot;
      logic [31:0] found_generation;
      logic [6:0]  live_entries;
      logic [6:0]  fallback_entries;
      logic [31:0] created_in_frame;
      logic [31:0] destroyed_in_frame;
      logic [31:0] reused_in_frame;
      logic [31:0] stale_total;
      logic [31:0] created_total;
      logic [31:0] destroyed_total;
      logic [31:0] reused_total;
   } rsp_type;

   typedef struct packed {
      logic [63:0] key;
      logic [31:0] slot;
      logic [31:0] generation;
      logic        fallback;
   } entry_type;

endpackage
`default_nettype wire

[sv/chmt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module chmt_ram
   import chmt_pkg::*;
#(
   parameter int WIDTH = 64,
   parameter int DEPTH = CHMT_HISTORY_DEPTH,
   parameter int AW    = 5
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[raddr];
   end

   assign rdata = rd_ff;

endmodule
`default_nettype wire

[sv/chunk_handle_map_table_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Chunk handle map table.
// req_* carries one request (opcode, id, handle, fallback flag); rsp_* returns
// one response per request with the handle on a lookup hit and all counters.
// One request is worked at a time; req_stall is high while it is in flight.
// Entries and destroyed-id history sit in single-port-read synchronous RAMs;
// a pipelined scan reads one entry per cycle.
// Steps: start_frame, clear_all and bad creates go straight to the response.
// Lookup / update: entry scan.
// New create: entry scan, then history scan.
// Destroy: entry scan, history scan, then read and write of the last entry.
// The next request is accepted in the cycle after a response is loaded.
// The response register lets the next request be accepted while the previous
// response is still stalled; a finished request waits in its last state until
// the response register frees up.
// Reset empties the table and history and zeroes all counters at once; no
// clearing pass is needed, since only entries below the fill counts are read.
module chunk_handle_map_table_unit
   import chmt_pkg::*;
#(
   parameter int TABLE_DEPTH   = CHMT_TABLE_DEPTH,
   parameter int HISTORY_DEPTH = CHMT_HISTORY_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int HW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CW  = $clog2(TABLE_DEPTH + 1);
   localparam int HCW = $clog2(HISTORY_DEPTH + 1);
   localparam int SW  = (CW > HCW) ? CW : HCW;
   localparam int EW  = $bits(entry_type);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ESCAN = 3'd1;
   localparam logic [2:0] S_HSCAN = 3'd2;
   localparam logic [2:0] S_MVRD  = 3'd3;
   localparam logic [2:0] S_MVWR  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]    state_ff, state_in;
   req_type       req_ff, req_in;
   logic [SW-1:0] scan_ff, scan_in;
   logic          pend_ff, pend_in;
   logic [SW-1:0] pidx_ff, pidx_in;
   logic [AW-1:0] eidx_ff, eidx_in;
   logic          oldfb_ff, oldfb_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] fbc_ff, fbc_in;
   logic [HCW-1:0] hcnt_ff, hcnt_in;
   logic [HW-1:0] head_ff, head_in;
   logic [31:0]   fc_ff [3];
   logic [31:0]   fc_in [3];
   logic [31:0]   tc_ff [4];
   logic [31:0]   tc_in [4];
   logic          ok_ff, ok_in;
   logic [31:0]   fslot_ff, fslot_in;
   logic [31:0]   fgen_ff, fgen_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          e_we;
   logic [AW-1:0] e_waddr, e_raddr;
   entry_type     e_wdata, e_rdata;
   logic          h_we;
   logic [HW-1:0] h_waddr;
   logic [63:0]   h_wdata, h_rdata;

   logic [SW-1:0] scan_lim;
   logic          issue;
   logic          e_hit, h_hit;
   logic [CW-1:0] cnt_m1;
   logic          rsp_free;

   chmt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH), .AW(AW)) u_entry_ram (
      .clock (clock),
      .we    (e_we),
      .waddr (e_waddr),
      .wdata (e_wdata),
      .raddr (e_raddr),
      .rdata (e_rdata)
   );

   chmt_ram #(.WIDTH(64), .DEPTH(HISTORY_DEPTH), .AW(HW)) u_hist_ram (
      .clock (clock),
      .we    (h_we),
      .waddr (h_waddr),
      .wdata (h_wdata),
      .raddr (scan_ff[HW-1:0]),
      .rdata (h_rdata)
   );

   assign cnt_m1   = cnt_ff - CW'(1);
   assign scan_lim = (state_ff == S_HSCAN) ? SW'(hcnt_ff) : SW'(cnt_ff);
   assign issue    = scan_ff < scan_lim;
   assign e_hit    = pend_ff && (e_rdata.key == req_ff.chunk_id);
   assign h_hit    = pend_ff && (h_rdata == req_ff.chunk_id);
   assign e_raddr  = (state_ff == S_MVRD) ? cnt_m1[AW-1:0] : scan_ff[AW-1:0];
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      scan_in  = scan_ff;
      pend_in  = pend_ff;
      pidx_in  = pidx_ff;
      eidx_in  = eidx_ff;
      oldfb_in = oldfb_ff;
      cnt_in   = cnt_ff;
      fbc_in   = fbc_ff;
      hcnt_in  = hcnt_ff;
      head_in  = head_ff;
      fc_in    = fc_ff;
      tc_in    = tc_ff;
      ok_in    = ok_ff;
      fslot_in = fslot_ff;
      fgen_in  = fgen_ff;
      e_we     = 1'b0;
      e_waddr  = eidx_ff;
      e_wdata  = '{key: req_ff.chunk_id, slot: req_ff.handle_slot,
                   generation: req_ff.handle_generation,
                   fallback: req_ff.fallback_flag};
      h_we     = 1'b0;
      h_waddr  = head_ff;
      h_wdata  = req_ff.chunk_id;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in   = rsp_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               ok_in    = 1'b0;
               fslot_in = '0;
               fgen_in  = '0;
               scan_in  = '0;
               pend_in  = 1'b0;
               state_in = S_DONE;
               case (req_payload.opcode)
                  OP_CREATE: begin
                     if (req_payload.chunk_id == '0 || req_payload.handle_slot == '0 ||
                         req_payload.handle_generation == '0) begin
                        tc_in[0] = tc_ff[0] + 32'd1;
                     end else begin
                        state_in = S_ESCAN;
                     end
                  end
                  OP_DESTROY, OP_LOOKUP: begin
                     state_in = S_ESCAN;
                  end
                  OP_START_FRAME: begin
                     fc_in = '{default: '0};
                     ok_in = 1'b1;
                  end
                  OP_CLEAR_ALL: begin
                     fc_in   = '{default: '0};
                     tc_in   = '{default: '0};
                     cnt_in  = '0;
                     fbc_in  = '0;
                     hcnt_in = '0;
                     head_in = '0;
                     ok_in   = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ESCAN: begin
            if (e_hit) begin
               eidx_in  = pidx_ff[AW-1:0];
               oldfb_in = e_rdata.fallback;
               case (req_ff.opcode)
                  OP_LOOKUP: begin
                     ok_in    = 1'b1;
                     fslot_in = e_rdata.slot;
                     fgen_in  = e_rdata.generation;
                     state_in = S_DONE;
                  end
                  OP_CREATE: begin
                     e_we     = 1'b1;
                     e_waddr  = pidx_ff[AW-1:0];
                     fbc_in   = fbc_ff - CW'(e_rdata.fallback)
                                + CW'(req_ff.fallback_flag);
                     ok_in    = 1'b1;
                     state_in = S_DONE;
                  end
                  default: begin
                     scan_in  = '0;
                     pend_in  = 1'b0;
                     state_in = S_HSCAN;
                  end
               endcase
            end else if (!issue && !pend_ff) begin
               state_in = S_DONE;
               case (req_ff.opcode)
                  OP_CREATE: begin
                     if (cnt_ff >= CW'(TABLE_DEPTH)) begin
                        tc_in[0] = tc_ff[0] + 32'd1;
                     end else begin
                        scan_in  = '0;
                        state_in = S_HSCAN;
                     end
                  end
                  OP_DESTROY: begin
                     tc_in[0] = tc_ff[0] + 32'd1;
                  end
                  default: begin
                  end
               endcase
            end else begin
               pend_in = issue;
               pidx_in = scan_ff;
               if (issue) begin
                  scan_in = scan_ff + SW'(1);
               end
            end
         end
         S_HSCAN: begin
            if (h_hit || (!issue && !pend_ff)) begin
               if (req_ff.opcode == OP_CREATE) begin
                  if (h_hit) begin
                     fc_in[2] = fc_ff[2] + 32'd1;
                     tc_in[3] = tc_ff[3] + 32'd1;
                  end
                  e_we     = 1'b1;
                  e_waddr  = cnt_ff[AW-1:0];
                  cnt_in   = cnt_ff + CW'(1);
                  fbc_in   = fbc_ff + CW'(req_ff.fallback_flag);
                  fc_in[0] = fc_ff[0] + 32'd1;
                  tc_in[1] = tc_ff[1] + 32'd1;
                  ok_in    = 1'b1;
                  state_in = S_DONE;
               end else begin
                  if (!h_hit) begin
                     h_we = 1'b1;
                     if (hcnt_ff == HCW'(HISTORY_DEPTH)) begin
                        h_waddr = head_ff;
                        head_in = (head_ff == HW'(HISTORY_DEPTH - 1)) ? '0
                                  : head_ff + HW'(1);
                     end else begin
                        h_waddr = hcnt_ff[HW-1:0];
                        hcnt_in = hcnt_ff + HCW'(1);
                     end
                  end
                  state_in = S_MVRD;
               end
            end else begin
               pend_in = issue;
               pidx_in = scan_ff;
               if (issue) begin
                  scan_in = scan_ff + SW'(1);
               end
            end
         end
         S_MVRD: begin
            state_in = S_MVWR;
         end
         S_MVWR: begin
            // last entry fills the hole
            e_we     = 1'b1;
            e_waddr  = eidx_ff;
            e_wdata  = e_rdata;
            cnt_in   = cnt_m1;
            fbc_in   = fbc_ff - CW'(oldfb_ff);
            fc_in[1] = fc_ff[1] + 32'd1;
            tc_in[2] = tc_ff[2] + 32'd1;
            ok_in    = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{success: ok_ff, found_slot: fslot_ff, found_generation: fgen_ff,
                          live_entries: 7'(cnt_ff), fallback_entries: 7'(fbc_ff),
                          created_in_frame: fc_ff[0], destroyed_in_frame: fc_ff[1],
                          reused_in_frame: fc_ff[2], stale_total: tc_ff[0],
                          created_total: tc_ff[1], destroyed_total: tc_ff[2],
                          reused_total: tc_ff[3]};
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         cnt_ff       <= '0;
         fbc_ff       <= '0;
         hcnt_ff      <= '0;
         head_ff      <= '0;
         fc_ff        <= '{default: '0};
         tc_ff        <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         fbc_ff       <= fbc_in;
         hcnt_ff      <= hcnt_in;
         head_ff      <= head_in;
         fc_ff        <= fc_in;
         tc_ff        <= tc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      scan_ff  <= scan_in;
      pidx_ff  <= pidx_in;
      eidx_ff  <= eidx_in;
      oldfb_ff <= oldfb_in;
      ok_ff    <= ok_in;
      fslot_ff <= fslot_in;
      fgen_ff  <= fgen_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`include "chunk_handle_map_table_unit_assert.svh"

   `CHMT_ASSERT_HOLDS(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CW'(TABLE_DEPTH))
   `CHMT_ASSERT_HOLDS(a_hist_bound, clock, reset, 1'b1, hcnt_ff <= HCW'(HISTORY_DEPTH))
   `CHMT_ASSERT_HOLDS(a_fb_bound, clock, reset, 1'b1, fbc_ff <= cnt_ff)
   `CHMT_ASSERT_NEXT(a_done_loads, clock, reset, state_ff == S_DONE && rsp_free, rsp_valid_ff)

endmodule
`default_nettype wire

[sim/tb_chunk_handle_map_table_unit.sv]
`timescale 1ns / 1ps
module tb_chunk_handle_map_table_unit;
   import chmt_pkg::*;

   localparam int TDEPTH = CHMT_TABLE_DEPTH;
   localparam int HDEPTH = CHMT_HISTORY_DEPTH;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   chunk_handle_map_table_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   entry_type   map_entry[TDEPTH];
   int unsigned map_count;
   logic [63:0] hist_id[HDEPTH];
   int unsigned hist_count;
   logic [31:0] frm_created, frm_destroyed, frm_reused;
   logic [31:0] tot_stale, tot_created, tot_destroyed, tot_reused;

   req_type     request_queue[$];
   rsp_type     expected_rsp[$];
   int          mismatch_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          send_hold = 1'b0;

   // ids from a small pool so hits, reuse and history shifts happen often
   logic [63:0] id_pool[48];

   function automatic int find_entry(logic [63:0] id);
      for (int i = 0; i < map_count; i++)
         if (map_entry[i].key == id) return i;
      return -1;
   endfunction

   function automatic bit in_history(logic [63:0] id);
      for (int i = 0; i < hist_count; i++)
         if (hist_id[i] == id) return 1'b1;
      return 1'b0;
   endfunction

   function automatic rsp_type predict_table(req_type r);
      rsp_type e;
      int idx;
      int unsigned nfb;
      e = '0;
      nfb = 0;
      case (r.opcode)
         OP_CREATE: begin
            idx = find_entry(r.chunk_id);
            if (r.chunk_id == 0 || r.handle_slot == 0 || r.handle_generation == 0) begin
               tot_stale++;
            end else if (idx >= 0) begin
               map_entry[idx].slot = r.handle_slot;
               map_entry[idx].generation = r.handle_generation;
               map_entry[idx].fallback = r.fallback_flag;
               e.success = 1'b1;
            end else if (map_count >= TDEPTH) begin
               tot_stale++;
            end else begin
               if (in_history(r.chunk_id)) begin
                  frm_reused++;
                  tot_reused++;
               end
               map_entry[map_count] = '{r.chunk_id, r.handle_slot,
                                        r.handle_generation, r.fallback_flag};
               map_count++;
               frm_created++;
               tot_created++;
               e.success = 1'b1;
            end
         end
         OP_DESTROY: begin
            idx = find_entry(r.chunk_id);
            if (idx < 0) begin
               tot_stale++;
            end else begin
               if (!in_history(r.chunk_id)) begin
                  if (hist_count < HDEPTH) begin
                     hist_id[hist_count] = r.chunk_id;
                     hist_count++;
                  end else begin
                     for (int i = 1; i < HDEPTH; i++) hist_id[i-1] = hist_id[i];
                     hist_id[HDEPTH-1] = r.chunk_id;
                  end
               end
               map_entry[idx] = map_entry[map_count-1];
               map_count--;
               frm_destroyed++;
               tot_destroyed++;
               e.success = 1'b1;
            end
         end
         OP_LOOKUP: begin
            idx = find_entry(r.chunk_id);
            if (idx >= 0) begin
               e.success = 1'b1;
               e.found_slot = map_entry[idx].slot;
               e.found_generation = map_entry[idx].generation;
            end
         end
         OP_START_FRAME: begin
            frm_created = 0; frm_destroyed = 0; frm_reused = 0;
            e.success = 1'b1;
         end
         OP_CLEAR_ALL: begin
            map_count = 0;
            hist_count = 0;
            frm_created = 0; frm_destroyed = 0; frm_reused = 0;
            tot_stale = 0; tot_created = 0; tot_destroyed = 0; tot_reused = 0;
            e.success = 1'b1;
         end
         default: ;
      endcase
      for (int i = 0; i < map_count; i++) nfb += map_entry[i].fallback;
      e.live_entries = map_count[6:0];
      e.fallback_entries = nfb[6:0];
      e.created_in_frame = frm_created;
      e.destroyed_in_frame = frm_destroyed;
      e.reused_in_frame = frm_reused;
      e.stale_total = tot_stale;
      e.created_total = tot_created;
      e.destroyed_total = tot_destroyed;
      e.reused_total = tot_reused;
      return e;
   endfunction

   function automatic req_type make_request(logic [2:0] op, logic [63:0] id,
                                            logic [31:0] slot, logic [31:0] gen,
                                            logic fb);
      req_type r;
      r.opcode = op;
      r.chunk_id = id;
      r.handle_slot = slot;
      r.handle_generation = gen;
      r.fallback_flag = fb;
      return r;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'hFFFF_FFFF;
         1: return 32'd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_request();
      int k;
      logic [2:0] op;
      logic [63:0] id;
      k = $urandom_range(0, 99);
      if (k < 40) op = OP_CREATE;
      else if (k < 70) op = OP_DESTROY;
      else if (k < 90) op = OP_LOOKUP;
      else if (k < 95) op = OP_START_FRAME;
      else if (k < 97) op = OP_CLEAR_ALL;
      else op = 3'($urandom_range(5, 7));
      k = $urandom_range(0, 19);
      if (k == 0) id = '0;
      else if (k == 1) id = {$urandom, $urandom};
      else id = id_pool[$urandom_range(0, 47)];
      return make_request(op, id, ($urandom_range(0, 30) == 0) ? 32'd0 : rand_word(),
                          ($urandom_range(0, 30) == 0) ? 32'd0 : rand_word(),
                          1'($urandom));
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_valid || !req_stall) begin
            if (request_queue.size() != 0 && !send_hold &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               req_payload <= request_queue[0];
               req_valid   <= 1'b1;
               expected_rsp.push_back(predict_table(request_queue.pop_front()));
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response %h", rsp_payload);
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_payload !== e) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p actual %p", e, rsp_payload);
            end
         end
      end
   end

   task automatic drain_all();
      while (request_queue.size() != 0 || expected_rsp.size() != 0 || req_valid)
         @(posedge clock);
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, int count);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         // random mix of operations over the shared id pool
         request_queue.push_back(random_request());
      end
      drain_all();
   endtask

   initial begin
      for (int i = 0; i < 48; i++) id_pool[i] = {$urandom, $urandom} | 64'd1;
      id_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
      id_pool[1] = 64'd1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed
      request_queue.push_back(make_request(OP_LOOKUP, 64'd5, 0, 0, 0));
      request_queue.push_back(make_request(OP_DESTROY, 64'd0, 0, 0, 0));
      request_queue.push_back(make_request(OP_CREATE, 64'd0, 32'd1, 32'd1, 1));
      request_queue.push_back(make_request(OP_CREATE, 64'd7, 32'd0, 32'd1, 1));
      request_queue.push_back(make_request(OP_CREATE, 64'd7, 32'd1, 32'd0, 1));
      request_queue.push_back(make_request(OP_CREATE, 64'hFFFF_FFFF_FFFF_FFFF,
                                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
      request_queue.push_back(make_request(OP_CREATE, 64'd1, 32'd1, 32'd1, 0));
      request_queue.push_back(make_request(OP_CREATE, 64'd1, 32'h5555_AAAA,
                                           32'hAAAA_5555, 1));
      request_queue.push_back(make_request(OP_LOOKUP, 64'd1, 0, 0, 0));
      request_queue.push_back(make_request(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0));
      request_queue.push_back(make_request(OP_DESTROY, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0));
      request_queue.push_back(make_request(OP_DESTROY, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0));
      request_queue.push_back(make_request(OP_CREATE, 64'hFFFF_FFFF_FFFF_FFFF,
                                           32'd3, 32'd4, 0));
      request_queue.push_back(make_request(OP_DESTROY, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0));
      request_queue.push_back(make_request(OP_START_FRAME, 0, 0, 0, 0));
      request_queue.push_back(make_request(3'd5, 64'd1, 32'd1, 32'd1, 1));
      request_queue.push_back(make_request(3'd6, 64'd1, 32'd1, 32'd1, 1));
      request_queue.push_back(make_request(3'd7, 64'd1, 32'd1, 32'd1, 1));
      // fill past full, destroy 40 so history wraps, then recreate for reuse
      for (int i = 0; i < 66; i++)
         request_queue.push_back(make_request(OP_CREATE, 64'h100 + i, 32'd9, 32'd9, 1'(i)));
      for (int i = 0; i < 40; i++)
         request_queue.push_back(make_request(OP_DESTROY, 64'h100 + i, 0, 0, 0));
      for (int i = 0; i < 12; i++)
         request_queue.push_back(make_request(OP_CREATE, 64'h100 + i, 32'd2, 32'd2, 1));
      request_queue.push_back(make_request(OP_CLEAR_ALL, 0, 0, 0, 0));
      request_queue.push_back(make_request(OP_LOOKUP, 64'h120, 0, 0, 0));
      drain_all();

      // sender pauses until everything has come back between phases
      run_phase(0, 0, 360);
      send_hold = 1'b1;
      repeat (20) @(posedge clock);
      send_hold = 1'b0;
      run_phase(66, 0, 330);
      run_phase(0, 66, 330);
      run_phase(31, 31, 330);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

   initial begin
      for (int i = 0; i < TDEPTH; i++) map_entry[i] = '0;
      for (int i = 0; i < HDEPTH; i++) hist_id[i] = '0;
      map_count = 0; hist_count = 0;
      frm_created = 0; frm_destroyed = 0; frm_reused = 0;
      tot_stale = 0; tot_created = 0; tot_destroyed = 0; tot_reused = 0;
   end
endmodule

[filelist.f]
+incdir+sv
sv/chmt_pkg.sv
sv/chmt_ram.sv
sv/chunk_handle_map_table_unit.sv
sim/tb_chunk_handle_map_table_unit.sv
